// ===== hw/rtl/flg_pkg.sv =====
// Shared constants, types and the sine table of the flanger.
package flg_pkg;

    localparam int DELAY_DEPTH = 512;
    localparam int SINE_SIZE   = 256;
    localparam int PHASE_BITS  = 20;

    localparam int AW        = $clog2(DELAY_DEPTH);
    localparam int IDX_BITS  = $clog2(SINE_SIZE);
    localparam int SAMPLE_W  = 16;
    localparam int STEP_W    = 16;
    localparam int DLY_W     = 17;
    localparam int GAIN_W    = 16;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;
    localparam int UNIT_W    = 17;
    localparam int FRAC_W    = 8;
    localparam int DQ_W      = AW + FRAC_W;
    localparam int DSUM_W    = DLY_W + 1;
    localparam int UNIT_SH   = 16;

    localparam int MUL_A_W   = 25;
    localparam int MUL_B_W   = 18;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W     = MUL_A_W;
    localparam int ROUND_SH  = 23;
    localparam int RND_W     = MUL_P_W + 1 - ROUND_SH;
    localparam int Y_W       = RND_W + 1;

    localparam logic [DQ_W-1:0] DLY_LO = DQ_W'(1 << FRAC_W);
    localparam logic [DQ_W-1:0] DLY_HI = DQ_W'((DELAY_DEPTH - 1) * (1 << FRAC_W));

    localparam logic signed [Y_W-1:0] SAT_MAX = Y_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [Y_W-1:0] SAT_MIN = -Y_W'(1 << (SAMPLE_W - 1));

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LFO_STEP    = 2'd0,
        CFG_DELAY_MIN   = 2'd1,
        CFG_DELAY_SWEEP = 2'd2,
        CFG_MIX_GAIN    = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LFO,
        S_DELAY,
        S_TAP_RD,
        S_MAC_A,
        S_MAC_B,
        S_GAIN,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        MUL_SWEEP,
        MUL_TAP_A,
        MUL_TAP_B,
        MUL_GAIN
    } mul_op_t;

    typedef struct packed {
        logic          in_ready;
        logic          ld_u;
        logic          ld_d;
        logic          rd_b;
        logic          acc_ld;
        logic          acc_add;
        logic          y_en;
        logic          out_load;
        logic          clr_we;
        logic [AW-1:0] clr_addr;
        mul_op_t       mul_op;
    } ctrl_t;

    typedef logic [UNIT_W-1:0] sine_lut_t [SINE_SIZE];

    // (1+sin)/2 per entry, Q16, parabolic approximation
    function automatic sine_lut_t build_sine();
        sine_lut_t       lut;
        longint unsigned two;
        longint unsigned x;
        longint unsigned s;
        longint unsigned c;
        longint unsigned y;
        logic            neg;
        for (int i = 0; i < SINE_SIZE; i++)
        begin
            two = longint'(i) * 2;
            neg = 1'b0;
            if (two >= longint'(SINE_SIZE))
            begin
                two = two - longint'(SINE_SIZE);
                neg = 1'b1;
            end
            x = (two * 65536) / SINE_SIZE;
            if (x > 65536)
                x = 65536;
            s = (4 * x * (65536 - x)) >> 16;
            c = 50790 + ((14746 * s) >> 16);
            y = (s * c) >> 16;
            if (y > 65536)
                y = 65536;
            lut[i] = neg ? UNIT_W'(32768 - (y >> 1)) : UNIT_W'(32768 + (y >> 1));
        end
        return lut;
    endfunction

    localparam sine_lut_t SINE_LUT = build_sine();

endpackage

// ===== hw/rtl/flg_mul.sv =====
// Shared signed multiplier of the flanger datapath.
module flg_mul (
    input  logic signed [flg_pkg::MUL_A_W-1:0] a,
    input  logic signed [flg_pkg::MUL_B_W-1:0] b,
    output logic signed [flg_pkg::MUL_P_W-1:0] p
);
    import flg_pkg::*;

    always_comb
    begin
        p = MUL_P_W'(a) * MUL_P_W'(b);
    end

endmodule

// ===== hw/rtl/flg_delay_ram.sv =====
// Circular sample store: one write port, one registered read port.
module flg_delay_ram (
    input  logic                                clk,
    input  logic                                we,
    input  logic        [flg_pkg::AW-1:0]       wr_addr,
    input  logic signed [flg_pkg::SAMPLE_W-1:0] wr_data,
    input  logic        [flg_pkg::AW-1:0]       rd_addr,
    output logic signed [flg_pkg::SAMPLE_W-1:0] rd_data
);
    import flg_pkg::*;

    logic signed [SAMPLE_W-1:0] mem [DELAY_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/flg_seq.sv =====
// Sequencer: store clear after reset and the per-sample step schedule.
module flg_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           out_free,
    output flg_pkg::ctrl_t ctrl
);
    import flg_pkg::*;

    state_t        state_reg;
    state_t        state_next;
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] clr_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DELAY_DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_LFO;
            end
            S_LFO:    state_next = S_DELAY;
            S_DELAY:  state_next = S_TAP_RD;
            S_TAP_RD: state_next = S_MAC_A;
            S_MAC_A:  state_next = S_MAC_B;
            S_MAC_B:  state_next = S_GAIN;
            S_GAIN:   state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl          = '0;
        ctrl.clr_addr = clr_cnt_reg;
        ctrl.mul_op   = MUL_SWEEP;
        unique case (state_reg)
            S_CLEAR:  ctrl.clr_we   = 1'b1;
            S_IDLE:   ctrl.in_ready = 1'b1;
            S_LFO:    ctrl.ld_u     = 1'b1;
            S_DELAY:
            begin
                ctrl.ld_d   = 1'b1;
                ctrl.mul_op = MUL_SWEEP;
            end
            S_TAP_RD: ctrl.rd_b = 1'b0;
            S_MAC_A:
            begin
                ctrl.rd_b   = 1'b1;
                ctrl.acc_ld = 1'b1;
                ctrl.mul_op = MUL_TAP_A;
            end
            S_MAC_B:
            begin
                ctrl.acc_add = 1'b1;
                ctrl.mul_op  = MUL_TAP_B;
            end
            S_GAIN:
            begin
                ctrl.y_en   = 1'b1;
                ctrl.mul_op = MUL_GAIN;
            end
            S_DONE:   ctrl.out_load = out_free;
            default:  ctrl.in_ready = 1'b0;
        endcase
    end

endmodule

// ===== hw/rtl/flanger_audio_effect.sv =====
// Flanger top level: config registers, LFO, delay taps, mix and output register.
//
// One 16-bit sample in, one flanged sample out. After reset the block zeroes
// every entry of the delay store (in_ready low; config writes still taken).
// Each sample then steps from acceptance through the states LFO, DELAY,
// TAP_RD, MAC_A, MAC_B, GAIN and DONE to a result in the output register;
// the next one is taken back in IDLE, where in_ready is high. The schedule
// is set by one shared multiplier used four times per sample (sweep scaling,
// two interpolation taps, mix gain) and by the two tap reads through the
// single read port of the delay RAM. The output register holds a result until
// taken; the next sample is accepted meanwhile and finishes only once the
// register is free. Write config only while idle.
module flanger_audio_effect (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [flg_pkg::SAMPLE_W-1:0]  sample_in,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [flg_pkg::SAMPLE_W-1:0]  sample_out,
    input  logic                                 cfg_we,
    input  logic        [flg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [flg_pkg::CFG_W-1:0]     cfg_data
);
    import flg_pkg::*;

    ctrl_t ctrl;

    logic [STEP_W-1:0] lfo_step_reg;
    logic [DLY_W-1:0]  delay_min_reg;
    logic [DLY_W-1:0]  delay_sweep_reg;
    logic [GAIN_W-1:0] mix_gain_reg;

    logic [PHASE_BITS-1:0]      phase_reg;
    logic [AW-1:0]              wp_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic [UNIT_W-1:0]          u_reg;
    logic [DQ_W-1:0]            d_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_data_reg;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_P_W-1:0]  mul_p;

    logic [DSUM_W-1:0]          d_sum;
    logic [DQ_W-1:0]            d_clamp;
    logic [AW-1:0]              tap_k;
    logic [FRAC_W-1:0]          tap_f;
    logic [FRAC_W:0]            tap_f_inv;
    logic [AW-1:0]              tap_a_addr;
    logic [AW-1:0]              tap_b_addr;

    logic                       mem_we;
    logic [AW-1:0]              mem_wr_addr;
    logic signed [SAMPLE_W-1:0] mem_wr_data;
    logic [AW-1:0]              mem_rd_addr;
    logic signed [SAMPLE_W-1:0] mem_rd_data;

    logic signed [MUL_P_W:0]    rnd_sum;
    logic signed [RND_W-1:0]    rnd_q;
    logic signed [Y_W-1:0]      y_sum;
    logic signed [SAMPLE_W-1:0] y_sat;
    logic                       out_free;

    flg_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    flg_mul u_mul (
        .a (mul_a),
        .b (mul_b),
        .p (mul_p)
    );

    flg_delay_ram u_ram (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign in_ready   = ctrl.in_ready;
    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;
    assign out_free   = !out_valid_reg || out_ready;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfo_step_reg    <= STEP_W'(33);
            delay_min_reg   <= DLY_W'(256);
            delay_sweep_reg <= DLY_W'(50944);
            mix_gain_reg    <= GAIN_W'(16384);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LFO_STEP:    lfo_step_reg    <= cfg_data[STEP_W-1:0];
                CFG_DELAY_MIN:   delay_min_reg   <= cfg_data[DLY_W-1:0];
                CFG_DELAY_SWEEP: delay_sweep_reg <= cfg_data[DLY_W-1:0];
                CFG_MIX_GAIN:    mix_gain_reg    <= cfg_data[GAIN_W-1:0];
                default:         lfo_step_reg    <= lfo_step_reg;
            endcase
        end
    end

    // delay and tap addresses
    assign d_sum = DSUM_W'(delay_min_reg) + DSUM_W'(mul_p[UNIT_SH +: DLY_W]);

    always_comb
    begin
        if (d_sum < DSUM_W'(DLY_LO))
            d_clamp = DLY_LO;
        else if (d_sum > DSUM_W'(DLY_HI))
            d_clamp = DLY_HI;
        else
            d_clamp = d_sum[DQ_W-1:0];
    end

    assign tap_k      = d_reg[DQ_W-1:FRAC_W];
    assign tap_f      = d_reg[FRAC_W-1:0];
    assign tap_f_inv  = (FRAC_W + 1)'(1 << FRAC_W) - (FRAC_W + 1)'(tap_f);
    assign tap_a_addr = wp_reg - tap_k;
    assign tap_b_addr = tap_a_addr - AW'(1);

    // shared multiplier operands
    always_comb
    begin
        unique case (ctrl.mul_op)
            MUL_SWEEP:
            begin
                mul_a = MUL_A_W'(u_reg);
                mul_b = MUL_B_W'(delay_sweep_reg);
            end
            MUL_TAP_A:
            begin
                mul_a = MUL_A_W'(mem_rd_data);
                mul_b = MUL_B_W'(tap_f_inv);
            end
            MUL_TAP_B:
            begin
                mul_a = MUL_A_W'(mem_rd_data);
                mul_b = MUL_B_W'(tap_f);
            end
            MUL_GAIN:
            begin
                mul_a = acc_reg;
                mul_b = MUL_B_W'(mix_gain_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // round half up at 2^-23, add dry sample, saturate
    assign rnd_sum = (MUL_P_W + 1)'(mul_p) + (MUL_P_W + 1)'(1 << (ROUND_SH - 1));
    assign rnd_q   = rnd_sum[MUL_P_W:ROUND_SH];
    assign y_sum   = Y_W'(x_reg) + Y_W'(rnd_q);

    always_comb
    begin
        if (y_sum > SAT_MAX)
            y_sat = SAT_MAX[SAMPLE_W-1:0];
        else if (y_sum < SAT_MIN)
            y_sat = SAT_MIN[SAMPLE_W-1:0];
        else
            y_sat = y_sum[SAMPLE_W-1:0];
    end

    // delay RAM ports
    assign mem_we      = ctrl.clr_we || ctrl.y_en;
    assign mem_wr_addr = ctrl.clr_we ? ctrl.clr_addr : wp_reg;
    assign mem_wr_data = ctrl.clr_we ? SAMPLE_W'(0) : x_reg;
    assign mem_rd_addr = ctrl.rd_b ? tap_b_addr : tap_a_addr;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.y_en)
            begin
                phase_reg <= phase_reg + PHASE_BITS'(lfo_step_reg);
                wp_reg    <= wp_reg + AW'(1);
            end
            if (ctrl.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_valid && ctrl.in_ready)
            x_reg <= sample_in;
        if (ctrl.ld_u)
            u_reg <= SINE_LUT[phase_reg[PHASE_BITS-1 -: IDX_BITS]];
        if (ctrl.ld_d)
            d_reg <= d_clamp;
        if (ctrl.acc_ld)
            acc_reg <= mul_p[ACC_W-1:0];
        else if (ctrl.acc_add)
            acc_reg <= acc_reg + mul_p[ACC_W-1:0];
        if (ctrl.y_en)
            y_reg <= y_sat;
        if (ctrl.out_load)
            out_data_reg <= y_reg;
    end

endmodule

// ===== verif/flanger_checker.sv =====
`timescale 1ns / 100ps
// Flanger checker: tracks delay line, LFO and registers, predicts and compares each output beat.
module flanger_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic signed [flg_pkg::SAMPLE_W-1:0]  sample_in,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic signed [flg_pkg::SAMPLE_W-1:0]  sample_out,
    input  logic                                 cfg_we,
    input  logic        [flg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [flg_pkg::CFG_W-1:0]     cfg_data,
    output int                                   errors,
    output int                                   pending
);
    import flg_pkg::*;

    logic signed [SAMPLE_W-1:0] history [DELAY_DEPTH];
    logic [AW-1:0]              wr_ptr;
    logic [PHASE_BITS-1:0]      lfo_acc;
    logic [STEP_W-1:0]          step_reg;
    logic [DLY_W-1:0]           dmin_reg;
    logic [DLY_W-1:0]           sweep_reg;
    logic [GAIN_W-1:0]          gain_reg;
    logic signed [SAMPLE_W-1:0] flanged_q [$];
    logic signed [SAMPLE_W-1:0] want;

    // (1+sin)/2 in Q16; upper half of the table is the mirrored lobe
    function automatic logic [UNIT_W-1:0] lfo_level(input logic [IDX_BITS-1:0] idx);
        longint unsigned pos;
        longint unsigned s;
        longint unsigned c;
        longint unsigned y;
        pos = longint'(idx[IDX_BITS-2:0]) * (2 * 65536 / SINE_SIZE);
        s   = (4 * pos * (65536 - pos)) >> 16;
        c   = 50790 + ((14746 * s) >> 16);
        y   = (s * c) >> 16;
        if (y > 65536)
            y = 65536;
        if (idx[IDX_BITS-1])
            return UNIT_W'(32768 - (y >> 1));
        else
            return UNIT_W'(32768 + (y >> 1));
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] flanged(input logic signed [SAMPLE_W-1:0] x);
        logic [UNIT_W-1:0] u;
        longint unsigned   dq;
        logic [AW-1:0]     k;
        logic [AW-1:0]     ia;
        logic [AW-1:0]     ib;
        int                f;
        longint            acc;
        longint            y;
        u  = lfo_level(lfo_acc[PHASE_BITS-1 -: IDX_BITS]);
        dq = longint'(dmin_reg) + ((longint'(sweep_reg) * longint'(u)) >> 16);
        if (dq < 256)
            dq = 256;
        if (dq > (DELAY_DEPTH - 1) * 256)
            dq = (DELAY_DEPTH - 1) * 256;
        k   = AW'(dq >> 8);
        f   = int'(dq & 255);
        ia  = wr_ptr - k;
        ib  = wr_ptr - k - AW'(1);
        acc = longint'(256 - f) * longint'(history[ia]) + longint'(f) * longint'(history[ib]);
        acc = acc * longint'(gain_reg);
        y   = longint'(x) + ((acc + 64'sd4194304) >>> 23);
        if (y > 32767)
            y = 32767;
        if (y < -32768)
            y = -32768;
        return SAMPLE_W'(y);
    endfunction

    task automatic report(input string msg);
        $display("[%0t] flanger mismatch: %s", $time, msg);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DELAY_DEPTH; i++)
                history[i] = '0;
            wr_ptr    = '0;
            lfo_acc   = '0;
            step_reg  = 16'd33;
            dmin_reg  = 17'd256;
            sweep_reg = 17'd50944;
            gain_reg  = 16'd16384;
            flanged_q.delete();
            errors    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_LFO_STEP:    step_reg  = cfg_data[STEP_W-1:0];
                    CFG_DELAY_MIN:   dmin_reg  = cfg_data[DLY_W-1:0];
                    CFG_DELAY_SWEEP: sweep_reg = cfg_data[DLY_W-1:0];
                    CFG_MIX_GAIN:    gain_reg  = cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (flanged_q.size() == 0)
                    report($sformatf("output beat %0d with nothing pending", sample_out));
                else
                begin
                    want = flanged_q.pop_front();
                    if (sample_out !== want)
                        report($sformatf("sample_out %0d, predicted %0d", sample_out, want));
                end
            end
            if (in_valid && in_ready)
            begin
                flanged_q.push_back(flanged(sample_in));
                history[wr_ptr] = sample_in;
                wr_ptr  = wr_ptr + AW'(1);
                lfo_acc = lfo_acc + PHASE_BITS'(step_reg);
            end
        end
        pending = flanged_q.size();
    end

endmodule

// ===== verif/tb_flanger_audio_effect.sv =====
`timescale 1ns / 100ps
// Flanger testbench top: clock, reset, register setup, sample stimulus and verdict.
module tb_flanger_audio_effect;
    import flg_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 161;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample_in = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = CFG_LFO_STEP;
    logic [CFG_W-1:0]           cfg_data  = '0;

    int errors;
    int pending;
    int cycles    = 0;
    int send_idle = 0;
    int recv_idle = 0;
    logic signed [SAMPLE_W-1:0] last_sample = '0;

    logic signed [SAMPLE_W-1:0] edge_samples [12] = '{
        16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd0, -16'sd1,
        16'sd1, 16'sh5555, -16'sd21846, -16'sd32768, 16'sd32767, 16'sd0
    };
    logic signed [SAMPLE_W-1:0] long_dly_samples [6] = '{
        16'sd32767, -16'sd32768, -16'sd1, 16'sd1, 16'sd12345, -16'sd12345
    };
    logic signed [SAMPLE_W-1:0] frac_samples [7] = '{
        16'sd20000, -16'sd20000, 16'sd30000, 16'sd30000, -16'sd32768, 16'sd1024, 16'sd0
    };

    flanger_audio_effect dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    flanger_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .errors     (errors),
        .pending    (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** flanger_audio_effect: FAILED **");
            $finish;
        end
    end

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] s);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= s;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // drop valid, wait until every predicted beat is out, then let the pipe drain
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_config(input logic [STEP_W-1:0] step, input logic [DLY_W-1:0] dmin,
                              input logic [DLY_W-1:0] sweep, input logic [GAIN_W-1:0] gain);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LFO_STEP;
        cfg_data  <= CFG_W'(step);
        @(posedge clk);
        cfg_index <= CFG_DELAY_MIN;
        cfg_data  <= dmin;
        @(posedge clk);
        cfg_index <= CFG_DELAY_SWEEP;
        cfg_data  <= sweep;
        @(posedge clk);
        cfg_index <= CFG_MIX_GAIN;
        cfg_data  <= CFG_W'(gain);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // mix of full-scale noise, slow drift, near-rail runs and quiet passages
    function automatic logic signed [SAMPLE_W-1:0] audio_sample();
        logic signed [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = SAMPLE_W'($urandom);
            1: v = last_sample + SAMPLE_W'($urandom_range(0, 4095)) - 16'sd2048;
            2: v = $urandom_range(0, 1) ? 16'sh7FFF - SAMPLE_W'($urandom_range(0, 7))
                                        : 16'sh8000 + SAMPLE_W'($urandom_range(0, 7));
            default: v = SAMPLE_W'($urandom_range(0, 511)) - 16'sd256;
        endcase
        last_sample = v;
        return v;
    endfunction

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // one-sample delay at full gain: rails saturate
        set_config(16'hFFFF, 17'd256, 17'd0, 16'd32768);
        foreach (edge_samples[i])
            push_sample(edge_samples[i]);
        settle();

        // delay beyond the store clamps to the far end; zero gain passes input
        set_config(16'd0, 17'd130560, 17'd130560, 16'd0);
        foreach (long_dly_samples[i])
            push_sample(long_dly_samples[i]);
        settle();

        // fractional delay with the LFO stepping one table entry per beat
        set_config(16'd4096, 17'd384, 17'd1000, 16'd16384);
        foreach (frac_samples[i])
            push_sample(frac_samples[i]);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p / 3)
                0:       begin send_idle = 27; recv_idle = 88; end
                1:       begin send_idle = 88; recv_idle = 27; end
                default: begin send_idle = 0;  recv_idle = 0;  end
            endcase
            if (p == 0)
                set_config(16'd33, 17'd256, 17'd50944, 16'd16384);
            else if (p == 1)
                set_config(16'hFFFF, 17'd256, 17'd130560, 16'd32768);
            else if (p == 2)
                set_config(16'd0, 17'd130560, 17'd0, 16'd0);
            else
                set_config(STEP_W'($urandom),
                           $urandom_range(0, 1) ? DLY_W'($urandom_range(256, 4096))
                                                : DLY_W'($urandom_range(256, 130560)),
                           $urandom_range(0, 1) ? DLY_W'($urandom_range(0, 8192))
                                                : DLY_W'($urandom_range(0, 130560)),
                           GAIN_W'($urandom_range(0, 32768)));
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 4 && i == PHASE_ITEMS / 2)
                    settle();
                push_sample(audio_sample());
            end
            settle();
        end

        if (errors == 0 && pending == 0)
            $display("** flanger_audio_effect: PASSED **");
        else
            $display("** flanger_audio_effect: FAILED **");
        $finish;
    end

endmodule
